[hw/rtl/fpd_pkg.sv]
// Shared constants for the flight phase detector: phase and event codes,
// configuration register indexes and reset values. No dependencies.
`default_nettype none

package fpd_pkg;

  // Default number of fraction bits in the filter state.
  localparam int FRAC_BITS_DEFAULT = 8;

  // Flight phases.
  localparam logic [1:0] PH_READY   = 2'd0;
  localparam logic [1:0] PH_ASCENT  = 2'd1;
  localparam logic [1:0] PH_DESCENT = 2'd2;
  localparam logic [1:0] PH_LANDED  = 2'd3;

  // Events reported with each result item.
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_LAUNCH  = 2'd1;
  localparam logic [1:0] EV_APOGEE  = 2'd2;
  localparam logic [1:0] EV_LANDING = 2'd3;

  // Input item kinds.
  localparam logic KIND_PRIME  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;
  localparam logic [CFG_INDEX_W-1:0] REG_GROUND_PRESSURE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_PRESSURE   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_ACCEL      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LAUNCH_ACCEL     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_APOGEE_RISE      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LANDING_MARGIN   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_LANDING_TOLERANCE = 3'd6;

  // Register reset values.
  localparam logic [16:0] GROUND_PRESSURE_RESET   = 17'd101325;
  localparam logic [8:0]  ALPHA_PRESSURE_RESET    = 9'd64;
  localparam logic [8:0]  ALPHA_ACCEL_RESET       = 9'd77;
  localparam logic [13:0] LAUNCH_ACCEL_RESET      = 14'd2000;
  localparam logic [13:0] APOGEE_RISE_RESET       = 14'd300;
  localparam logic [13:0] LANDING_MARGIN_RESET    = 14'd1000;
  localparam logic [11:0] LANDING_TOLERANCE_RESET = 12'd200;

  // One g in milli-g, and the largest smoothing factor (unity).
  localparam logic [14:0] ONE_G_MG  = 15'd1000;
  localparam logic [8:0]  ALPHA_MAX = 9'd256;

endpackage

`default_nettype wire

[hw/rtl/flight_phase_detector.sv]
// Flight phase detector top level: filters, minimum tracker and phase logic.
// Depends on fpd_pkg for codes, register indexes and reset values.
`default_nettype none

// Each accepted item is worked in the cycle it is accepted and its result
// appears in the output register on the next cycle; one item can be taken
// every cycle unless the output stalls. The limit is the combinational loop
// through the two smoothing multipliers (about (18+FRAC_BITS) x 10 bits) and
// the phase comparisons that follow them. A new item is taken whenever the
// output register is empty or its result is being taken in the same cycle.
// A prime item (kind 0) seeds both averages and the minimum from the sample
// and returns the phase to ready. Configuration writes take effect at once
// and are meant to happen only while the block is idle.
module flight_phase_detector #(
  parameter int FRAC_BITS = fpd_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Configuration write port
  input  wire logic                             cfg_we,
  input  wire logic [fpd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [fpd_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Input items
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             kind,
  input  wire logic [16:0]                      pressure_pa,
  input  wire logic signed [14:0]               accel_z_mg,
  // Result items
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [1:0]                            flight_phase,
  output logic [1:0]                            phase_event,
  output logic [16:0]                           smoothed_pressure,
  output logic signed [14:0]                    smoothed_accel,
  output logic [16:0]                           lowest_pressure
);
  import fpd_pkg::*;

  localparam int PW = 17 + FRAC_BITS;  // pressure state width, unsigned
  localparam int AW = 15 + FRAC_BITS;  // acceleration state width, signed

  localparam logic signed [AW:0] ONE_G_SCALED = $signed({1'b0, ONE_G_MG, {FRAC_BITS{1'b0}}});

  // Configuration registers
  logic [16:0] ground_pressure;
  logic [8:0]  alpha_pressure_q8;
  logic [8:0]  alpha_accel_q8;
  logic [13:0] launch_accel_mg;
  logic [13:0] apogee_rise_pa;
  logic [13:0] landing_margin_pa;
  logic [11:0] landing_tolerance_mg;

  // Filter and phase state
  logic [1:0]           phase_reg;
  logic [PW-1:0]        pressure_avg;
  logic signed [AW-1:0] accel_avg;
  logic [PW-1:0]        pressure_min;

  logic [1:0]           phase_next;
  logic [1:0]           event_next;
  logic [PW-1:0]        pressure_avg_next;
  logic signed [AW-1:0] accel_avg_next;
  logic [PW-1:0]        pressure_min_next;

  logic accept;

  // Smoothing datapath
  logic [8:0]            alpha_p_sat;
  logic [8:0]            alpha_a_sat;
  logic signed [9:0]     alpha_p;
  logic signed [9:0]     alpha_a;
  logic signed [PW:0]    p_diff;
  logic signed [AW:0]    a_diff;
  logic signed [PW+10:0] p_prod;
  logic signed [AW+10:0] a_prod;
  logic signed [PW+10:0] p_step;
  logic signed [AW+10:0] a_step;
  logic [PW-1:0]         p_ema;
  logic signed [AW-1:0]  a_ema;
  logic [PW-1:0]         p_scaled;
  logic signed [AW-1:0]  a_scaled;

  // Phase comparisons
  logic signed [AW:0] launch_thr;
  logic [PW-1:0]      min_tracked;
  logic [PW:0]        apogee_thr;
  logic signed [17:0] floor_base;
  logic signed [PW:0] floor_thr;
  logic signed [AW:0] accel_dev;
  logic [AW:0]        accel_dev_abs;
  logic [AW:0]        tol_thr;
  logic               launch_hit;
  logic               apogee_hit;
  logic               landing_hit;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    alpha_p_sat = (alpha_pressure_q8 > ALPHA_MAX) ? ALPHA_MAX : alpha_pressure_q8;
    alpha_a_sat = (alpha_accel_q8 > ALPHA_MAX) ? ALPHA_MAX : alpha_accel_q8;
    alpha_p     = $signed({1'b0, alpha_p_sat});
    alpha_a     = $signed({1'b0, alpha_a_sat});

    p_scaled = {pressure_pa, {FRAC_BITS{1'b0}}};
    a_scaled = $signed({accel_z_mg, {FRAC_BITS{1'b0}}});

    // The filtered value always lies between the old average and the sample,
    // so the low bits of the sum are exact.
    p_diff = $signed({1'b0, p_scaled}) - $signed({1'b0, pressure_avg});
    a_diff = (AW+1)'(a_scaled) - (AW+1)'(accel_avg);
    p_prod = p_diff * alpha_p;
    a_prod = a_diff * alpha_a;
    p_step = p_prod >>> 8;
    a_step = a_prod >>> 8;
    p_ema  = pressure_avg + p_step[PW-1:0];
    a_ema  = accel_avg + a_step[AW-1:0];

    launch_thr  = $signed({2'b00, launch_accel_mg, {FRAC_BITS{1'b0}}});
    launch_hit  = (AW+1)'(a_ema) > launch_thr;

    min_tracked = (p_ema < pressure_min) ? p_ema : pressure_min;
    apogee_thr  = {1'b0, min_tracked} + (PW+1)'({apogee_rise_pa, {FRAC_BITS{1'b0}}});
    apogee_hit  = {1'b0, p_ema} > apogee_thr;

    floor_base    = $signed({1'b0, ground_pressure}) - $signed({4'b0000, landing_margin_pa});
    floor_thr     = $signed({floor_base, {FRAC_BITS{1'b0}}});
    accel_dev     = (AW+1)'(a_ema) - ONE_G_SCALED;
    accel_dev_abs = accel_dev[AW] ? (AW+1)'(-accel_dev) : (AW+1)'(accel_dev);
    tol_thr       = (AW+1)'({landing_tolerance_mg, {FRAC_BITS{1'b0}}});
    landing_hit   = ($signed({1'b0, p_ema}) > floor_thr) && (accel_dev_abs < tol_thr);

    phase_next        = phase_reg;
    event_next        = EV_NONE;
    pressure_avg_next = p_ema;
    accel_avg_next    = a_ema;
    pressure_min_next = pressure_min;

    if (kind == KIND_PRIME) begin
      pressure_avg_next = p_scaled;
      accel_avg_next    = a_scaled;
      pressure_min_next = p_scaled;
      phase_next        = PH_READY;
    end else begin
      case (phase_reg)
        PH_READY: begin
          if (launch_hit) begin
            phase_next        = PH_ASCENT;
            pressure_min_next = p_ema;
            event_next        = EV_LAUNCH;
          end
        end
        PH_ASCENT: begin
          pressure_min_next = min_tracked;
          if (apogee_hit) begin
            phase_next = PH_DESCENT;
            event_next = EV_APOGEE;
          end
        end
        PH_DESCENT: begin
          if (landing_hit) begin
            phase_next = PH_LANDED;
            event_next = EV_LANDING;
          end
        end
        default: begin
          // Landed: the filters run on, phase and minimum hold.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ground_pressure      <= GROUND_PRESSURE_RESET;
      alpha_pressure_q8    <= ALPHA_PRESSURE_RESET;
      alpha_accel_q8       <= ALPHA_ACCEL_RESET;
      launch_accel_mg      <= LAUNCH_ACCEL_RESET;
      apogee_rise_pa       <= APOGEE_RISE_RESET;
      landing_margin_pa    <= LANDING_MARGIN_RESET;
      landing_tolerance_mg <= LANDING_TOLERANCE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GROUND_PRESSURE:   ground_pressure      <= cfg_data[16:0];
        REG_ALPHA_PRESSURE:    alpha_pressure_q8    <= cfg_data[8:0];
        REG_ALPHA_ACCEL:       alpha_accel_q8       <= cfg_data[8:0];
        REG_LAUNCH_ACCEL:      launch_accel_mg      <= cfg_data[13:0];
        REG_APOGEE_RISE:       apogee_rise_pa       <= cfg_data[13:0];
        REG_LANDING_MARGIN:    landing_margin_pa    <= cfg_data[13:0];
        REG_LANDING_TOLERANCE: landing_tolerance_mg <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg    <= PH_READY;
      pressure_avg <= {GROUND_PRESSURE_RESET, {FRAC_BITS{1'b0}}};
      accel_avg    <= $signed({ONE_G_MG, {FRAC_BITS{1'b0}}});
      pressure_min <= {GROUND_PRESSURE_RESET, {FRAC_BITS{1'b0}}};
    end else if (accept) begin
      phase_reg    <= phase_next;
      pressure_avg <= pressure_avg_next;
      accel_avg    <= accel_avg_next;
      pressure_min <= pressure_min_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register; the integer parts are the top bits of the state.
  always_ff @(posedge clk) begin
    if (accept) begin
      flight_phase      <= phase_next;
      phase_event       <= event_next;
      smoothed_pressure <= pressure_avg_next[PW-1:FRAC_BITS];
      smoothed_accel    <= accel_avg_next[AW-1:FRAC_BITS];
      lowest_pressure   <= pressure_min_next[PW-1:FRAC_BITS];
    end
  end

endmodule

`default_nettype wire
